// ----- design/imq_pkg.sv -----
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imq_pkg;

   localparam int VERTEX_W     = 10;
   localparam int VERTEX_SPACE = 1024;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 3;
   localparam int OCC_W        = 11;
   localparam int KEY_IN_W     = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 2'd0,
      CMD_DECREASE   = 2'd1,
      CMD_DELETE_MIN = 2'd2,
      CMD_CLEAR      = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_EMPTY       = 3'd1,
      STAT_FULL        = 3'd2,
      STAT_PRESENT     = 3'd3,
      STAT_ABSENT      = 3'd4,
      STAT_NOT_SMALLER = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_LOOKUP,
      S_DEC_EVAL,
      S_UP_READ,
      S_UP_EVAL,
      S_DOWN_READ,
      S_DOWN_EVAL,
      S_FINISH
   } state_type;

   // write request into the vertex map
   typedef struct packed {
      logic                we;
      logic [VERTEX_W-1:0] addr;
      logic                present;
   } map_write_type;

   // finished result handed to the output register
   typedef struct packed {
      logic                valid;
      logic [VERTEX_W-1:0] popped_vertex;
      logic [KEY_IN_W-1:0] popped_key;
      status_type          status;
      logic [OCC_W-1:0]    occupancy;
   } result_type;

endpackage

// ----- design/imq_req_if.sv -----
// ----------------------------------------------------------------------------
// imq_req_if
// Command channel: valid/ready handshake with command, vertex and key.
// ----------------------------------------------------------------------------
interface imq_req_if;
   logic                              valid;
   logic                              ready;
   logic [imq_pkg::CMD_W-1:0]         command;
   logic [imq_pkg::VERTEX_W-1:0]      vertex_id;
   logic [imq_pkg::KEY_IN_W-1:0]      key_value;

   modport source (output valid, output command, output vertex_id, output key_value,
                   input ready);
   modport sink   (input valid, input command, input vertex_id, input key_value,
                   output ready);
endinterface

// ----- design/imq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// imq_rsp_if
// Result channel: valid/ready handshake with popped pair, status, occupancy.
// ----------------------------------------------------------------------------
interface imq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [imq_pkg::VERTEX_W-1:0]      popped_vertex;
   logic [imq_pkg::KEY_IN_W-1:0]      popped_key;
   logic [imq_pkg::STATUS_W-1:0]      status;
   logic [imq_pkg::OCC_W-1:0]         occupancy;

   modport source (output valid, output popped_vertex, output popped_key, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input popped_vertex, input popped_key, input status,
                   input occupancy, output ready);
endinterface

// ----- design/indexed_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of (key, vertex) pairs with decrease-key.
// ----------------------------------------------------------------------------
// One command at a time, one result per command. An accepted command passes
// through the lookup, then a sift up for insert and decrease-key or a sift down
// for delete-min, one heap level per read and evaluate state pair, before its
// result is registered; decrease-key first checks its key. Status-only answers
// and a delete that empties the heap finish without a sift. The next item is
// taken the cycle after the result is registered. Each level costs one read and
// one write-back of the slot memory. After reset and on every clear the vertex
// map is swept one entry a cycle to mark all vertices absent; no command is
// taken meanwhile, and a clear answers after its sweep.
module indexed_min_heap_queue #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   imq_req_if.sink  req_ch,
   imq_rsp_if.source rsp_ch
);
   import imq_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   result_type                 result;
   logic                       result_room;
   logic                       slot_we;
   logic [SLOT_W-1:0]          slot_waddr, slot_raddr_a, slot_raddr_b;
   logic [KEY_BITS+VERTEX_W-1:0] slot_wdata, slot_rdata_a, slot_rdata_b;
   map_write_type              map_wr;
   logic [SLOT_W-1:0]          map_wslot, map_rslot;
   logic [VERTEX_W-1:0]        map_raddr;
   logic                       map_rpresent;

   logic                       rsp_valid_ff;
   logic [VERTEX_W-1:0]        rsp_vertex_ff;
   logic [KEY_IN_W-1:0]        rsp_key_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic [OCC_W-1:0]           rsp_occ_ff;

   assign result_room = !rsp_valid_ff || rsp_ch.ready;

   imq_ctrl #(
      .CAPACITY(CAPACITY), .SLOT_W(SLOT_W), .CNT_W(CNT_W), .KEY_BITS(KEY_BITS)
   ) u_ctrl (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .result_room(result_room), .result(result),
      .slot_we(slot_we), .slot_waddr(slot_waddr), .slot_wdata(slot_wdata),
      .slot_raddr_a(slot_raddr_a), .slot_raddr_b(slot_raddr_b),
      .slot_rdata_a(slot_rdata_a), .slot_rdata_b(slot_rdata_b),
      .map_wr(map_wr), .map_wslot(map_wslot), .map_raddr(map_raddr),
      .map_rpresent(map_rpresent), .map_rslot(map_rslot)
   );

   imq_slot_ram #(
      .CAPACITY(CAPACITY), .SLOT_W(SLOT_W), .KEY_BITS(KEY_BITS)
   ) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr_a(slot_raddr_a), .raddr_b(slot_raddr_b),
      .rdata_a_ff(slot_rdata_a), .rdata_b_ff(slot_rdata_b)
   );

   imq_map_ram #(
      .SLOT_W(SLOT_W)
   ) u_map_ram (
      .clock(clock), .wr(map_wr), .wslot(map_wslot), .raddr(map_raddr),
      .rpresent_ff(map_rpresent), .rslot_ff(map_rslot)
   );

   // output register, loaded when the sequencer finishes an item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && result_room) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid && result_room) begin
         rsp_vertex_ff <= result.popped_vertex;
         rsp_key_ff    <= result.popped_key;
         rsp_status_ff <= result.status;
         rsp_occ_ff    <= result.occupancy;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.popped_vertex = rsp_vertex_ff;
   assign rsp_ch.popped_key    = rsp_key_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;
endmodule

// ----- design/imq_slot_ram.sv -----
// ----------------------------------------------------------------------------
// imq_slot_ram
// Heap slot store: key and vertex per slot, one write and two read ports.
// ----------------------------------------------------------------------------
module imq_slot_ram #(
   parameter int CAPACITY,
   parameter int SLOT_W,
   parameter int KEY_BITS
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [SLOT_W-1:0]                     waddr,
   input  logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] wdata,
   input  logic [SLOT_W-1:0]                     raddr_a,
   input  logic [SLOT_W-1:0]                     raddr_b,
   output logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] rdata_a_ff,
   output logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] rdata_b_ff
);
   import imq_pkg::*;

   logic [KEY_BITS+VERTEX_W-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end
endmodule

// ----- design/imq_map_ram.sv -----
// ----------------------------------------------------------------------------
// imq_map_ram
// Vertex map store: present bit and heap slot per vertex.
// ----------------------------------------------------------------------------
module imq_map_ram #(
   parameter int SLOT_W
) (
   input  logic                         clock,
   input  imq_pkg::map_write_type       wr,
   input  logic [SLOT_W-1:0]            wslot,
   input  logic [imq_pkg::VERTEX_W-1:0] raddr,
   output logic                         rpresent_ff,
   output logic [SLOT_W-1:0]            rslot_ff
);
   import imq_pkg::*;

   logic [SLOT_W:0] mem [VERTEX_SPACE];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= {wr.present, wslot};
      end
      {rpresent_ff, rslot_ff} <= mem[raddr];
   end
endmodule

// ----- design/imq_ctrl.sv -----
// ----------------------------------------------------------------------------
// imq_ctrl
// Command sequencer: lookup, sift up and sift down over the two stores.
// ----------------------------------------------------------------------------
module imq_ctrl #(
   parameter int CAPACITY,
   parameter int SLOT_W,
   parameter int CNT_W,
   parameter int KEY_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   imq_req_if.sink                          req_ch,
   input  logic                             result_room,
   output imq_pkg::result_type              result,
   output logic                             slot_we,
   output logic [SLOT_W-1:0]                slot_waddr,
   output logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] slot_wdata,
   output logic [SLOT_W-1:0]                slot_raddr_a,
   output logic [SLOT_W-1:0]                slot_raddr_b,
   input  logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] slot_rdata_a,
   input  logic [KEY_BITS+imq_pkg::VERTEX_W-1:0] slot_rdata_b,
   output imq_pkg::map_write_type           map_wr,
   output logic [SLOT_W-1:0]                map_wslot,
   output logic [imq_pkg::VERTEX_W-1:0]     map_raddr,
   input  logic                             map_rpresent,
   input  logic [SLOT_W-1:0]                map_rslot
);
   import imq_pkg::*;

   localparam int IDX_W = SLOT_W + 2;

   state_type             state_ff, state_in;
   command_type           cmd_ff, cmd_in;
   logic [VERTEX_W-1:0]   vid_ff, vid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     pos_ff, pos_in;
   logic [KEY_BITS-1:0]   ekey_ff, ekey_in;
   logic [VERTEX_W-1:0]   evtx_ff, evtx_in;
   logic [VERTEX_W-1:0]   pv_ff, pv_in;
   logic [KEY_IN_W-1:0]   pk_ff, pk_in;
   status_type            status_ff, status_in;
   logic [VERTEX_W-1:0]   sweep_ff, sweep_in;
   logic                  rc_ok_ff, rc_ok_in;

   logic [KEY_BITS-1:0]   a_key, b_key;
   logic [VERTEX_W-1:0]   a_vtx, b_vtx;
   logic [IDX_W-1:0]      lc_idx, rc_idx, cnt_x;
   logic [SLOT_W-1:0]     parent;
   logic                  take_b;
   logic [KEY_BITS-1:0]   best_key;
   logic [VERTEX_W-1:0]   best_vtx;
   logic [SLOT_W-1:0]     best_pos;

   assign {a_key, a_vtx} = slot_rdata_a;
   assign {b_key, b_vtx} = slot_rdata_b;
   assign lc_idx   = {1'b0, pos_ff, 1'b1};
   assign rc_idx   = lc_idx + IDX_W'(1);
   assign cnt_x    = IDX_W'(count_ff);
   assign parent   = SLOT_W'((pos_ff - SLOT_W'(1)) >> 1);
   // right child wins only when strictly smaller
   assign take_b   = rc_ok_ff && (b_key < a_key);
   assign best_key = take_b ? b_key : a_key;
   assign best_vtx = take_b ? b_vtx : a_vtx;
   assign best_pos = take_b ? rc_idx[SLOT_W-1:0] : lc_idx[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         cmd_ff   <= CMD_INSERT;
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
      end
      vid_ff    <= vid_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      ekey_ff   <= ekey_in;
      evtx_ff   <= evtx_in;
      pv_ff     <= pv_in;
      pk_ff     <= pk_in;
      status_ff <= status_in;
      rc_ok_ff  <= rc_ok_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      vid_in    = vid_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      ekey_in   = ekey_ff;
      evtx_in   = evtx_ff;
      pv_in     = pv_ff;
      pk_in     = pk_ff;
      status_in = status_ff;
      sweep_in  = sweep_ff;
      rc_ok_in  = rc_ok_ff;

      req_ch.ready = 1'b0;
      slot_we      = 1'b0;
      slot_waddr   = pos_ff;
      slot_wdata   = {ekey_ff, evtx_ff};
      slot_raddr_a = '0;
      slot_raddr_b = SLOT_W'(count_ff - CNT_W'(1));
      map_wr       = '{we: 1'b0, addr: evtx_ff, present: 1'b1};
      map_wslot    = pos_ff;
      map_raddr    = req_ch.vertex_id;

      result.valid         = (state_ff == S_FINISH);
      result.popped_vertex = pv_ff;
      result.popped_key    = pk_ff;
      result.status        = status_ff;
      result.occupancy     = OCC_W'(count_ff);

      case (state_ff)
         S_SWEEP: begin
            map_wr    = '{we: 1'b1, addr: sweep_ff, present: 1'b0};
            map_wslot = '0;
            sweep_in  = sweep_ff + VERTEX_W'(1);
            if (sweep_ff == VERTEX_W'(VERTEX_SPACE - 1)) begin
               state_in = (cmd_ff == CMD_CLEAR) ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cmd_in    = command_type'(req_ch.command);
               vid_in    = req_ch.vertex_id;
               key_in    = KEY_BITS'(req_ch.key_value);
               pv_in     = '0;
               pk_in     = '0;
               status_in = STAT_OK;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            slot_raddr_a = map_rslot;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (map_rpresent) begin
                     status_in = STAT_PRESENT;
                     state_in  = S_FINISH;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     ekey_in  = key_ff;
                     evtx_in  = vid_ff;
                     pos_in   = SLOT_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_READ;
                  end
               end
               CMD_DECREASE: begin
                  if (!map_rpresent || (CNT_W'(map_rslot) >= count_ff)) begin
                     status_in = STAT_ABSENT;
                     state_in  = S_FINISH;
                  end else begin
                     pos_in   = map_rslot;
                     state_in = S_DEC_EVAL;
                  end
               end
               CMD_DELETE_MIN: begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     pv_in    = a_vtx;
                     pk_in    = KEY_IN_W'(a_key);
                     map_wr   = '{we: 1'b1, addr: a_vtx, present: 1'b0};
                     count_in = count_ff - CNT_W'(1);
                     ekey_in  = b_key;
                     evtx_in  = b_vtx;
                     pos_in   = '0;
                     state_in = (count_ff == CNT_W'(1)) ? S_FINISH : S_DOWN_READ;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  state_in = S_SWEEP;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_DEC_EVAL: begin
            if (key_ff >= a_key) begin
               status_in = STAT_NOT_SMALLER;
               state_in  = S_FINISH;
            end else begin
               ekey_in  = key_ff;
               evtx_in  = vid_ff;
               state_in = S_UP_READ;
            end
         end
         S_UP_READ: begin
            slot_raddr_a = parent;
            if (pos_ff == '0) begin
               // reached the root, place the held entry
               slot_we    = 1'b1;
               map_wr.we  = 1'b1;
               state_in   = S_FINISH;
            end else begin
               state_in = S_UP_EVAL;
            end
         end
         S_UP_EVAL: begin
            slot_we   = 1'b1;
            map_wr.we = 1'b1;
            if (a_key > ekey_ff) begin
               // parent moves down into the hole
               slot_wdata  = slot_rdata_a;
               map_wr.addr = a_vtx;
               pos_in      = parent;
               state_in    = S_UP_READ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DOWN_READ: begin
            slot_raddr_a = lc_idx[SLOT_W-1:0];
            slot_raddr_b = rc_idx[SLOT_W-1:0];
            rc_ok_in     = rc_idx < cnt_x;
            if (lc_idx >= cnt_x) begin
               slot_we   = 1'b1;
               map_wr.we = 1'b1;
               state_in  = S_FINISH;
            end else begin
               state_in = S_DOWN_EVAL;
            end
         end
         S_DOWN_EVAL: begin
            slot_we   = 1'b1;
            map_wr.we = 1'b1;
            if (best_key < ekey_ff) begin
               // smaller child moves up into the hole
               slot_wdata  = {best_key, best_vtx};
               map_wr.addr = best_vtx;
               pos_in      = best_pos;
               state_in    = S_DOWN_READ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (result_room) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- verif/tb_indexed_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue
// Self-checking regression of the indexed min-heap queue: a heap predictor
// scores every result, with directed corners, a full fill and random traffic.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;
   import imq_pkg::*;

   localparam int HEAP_SLOTS = 1024;
   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic [VERTEX_W-1:0] popped_vertex;
      logic [KEY_IN_W-1:0] popped_key;
      status_type          status;
      logic [OCC_W-1:0]    occupancy;
   } heap_answer_type;

   class heap_scoreboard;
      logic [KEY_IN_W-1:0] slot_key[HEAP_SLOTS];
      logic [VERTEX_W-1:0] slot_vtx[HEAP_SLOTS];
      int                  vtx_slot[VERTEX_SPACE];
      bit                  vtx_here[VERTEX_SPACE];
      int                  count;
      heap_answer_type     answers[$];
      int                  errors;
      int                  checked;
      int                  status_seen[6];

      function void wipe();
         foreach (vtx_here[i]) vtx_here[i] = 0;
         count = 0;
      endfunction

      function void swap(int a, int b);
         logic [KEY_IN_W-1:0] k;
         logic [VERTEX_W-1:0] v;
         k = slot_key[a]; v = slot_vtx[a];
         slot_key[a] = slot_key[b]; slot_vtx[a] = slot_vtx[b];
         slot_key[b] = k; slot_vtx[b] = v;
         vtx_slot[slot_vtx[a]] = a;
         vtx_slot[slot_vtx[b]] = b;
      endfunction

      function void climb(int pos);
         while (pos > 0 && slot_key[(pos - 1) / 2] > slot_key[pos]) begin
            swap(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
         end
      endfunction

      function void sink(int pos);
         int lc, best;
         forever begin
            lc = 2 * pos + 1;
            if (lc >= count) break;
            best = lc;
            if (lc + 1 < count && slot_key[lc + 1] < slot_key[lc]) best = lc + 1;
            if (slot_key[best] >= slot_key[pos]) break;
            swap(pos, best);
            pos = best;
         end
      endfunction

      function void note(command_type cmd, logic [VERTEX_W-1:0] vid,
                         logic [KEY_IN_W-1:0] key);
         heap_answer_type a;
         a.popped_vertex = '0;
         a.popped_key = '0;
         a.status = STAT_OK;
         case (cmd)
            CMD_INSERT: begin
               if (vtx_here[vid]) a.status = STAT_PRESENT;
               else if (count >= HEAP_SLOTS) a.status = STAT_FULL;
               else begin
                  slot_key[count] = key;
                  slot_vtx[count] = vid;
                  vtx_slot[vid] = count;
                  vtx_here[vid] = 1;
                  count++;
                  climb(count - 1);
               end
            end
            CMD_DECREASE: begin
               if (!vtx_here[vid]) a.status = STAT_ABSENT;
               else if (key >= slot_key[vtx_slot[vid]]) a.status = STAT_NOT_SMALLER;
               else begin
                  slot_key[vtx_slot[vid]] = key;
                  climb(vtx_slot[vid]);
               end
            end
            CMD_DELETE_MIN: begin
               if (count == 0) a.status = STAT_EMPTY;
               else begin
                  a.popped_vertex = slot_vtx[0];
                  a.popped_key = slot_key[0];
                  vtx_here[slot_vtx[0]] = 0;
                  count--;
                  if (count > 0) begin
                     slot_key[0] = slot_key[count];
                     slot_vtx[0] = slot_vtx[count];
                     vtx_slot[slot_vtx[0]] = 0;
                     sink(0);
                  end
               end
            end
            default: wipe();
         endcase
         a.occupancy = OCC_W'(count);
         status_seen[a.status]++;
         answers.push_back(a);
      endfunction

      task report(string what, logic [KEY_IN_W-1:0] got, logic [KEY_IN_W-1:0] want);
         $display("mismatch on %s: got %0h, expected %0h (result %0d)",
                  what, got, want, checked);
         errors++;
      endtask

      task check(logic [VERTEX_W-1:0] pv, logic [KEY_IN_W-1:0] pk,
                 logic [STATUS_W-1:0] st, logic [OCC_W-1:0] occ);
         heap_answer_type a;
         if (answers.size() == 0) begin
            report("unexpected result status", st, 0);
            return;
         end
         a = answers.pop_front();
         if (pv !== a.popped_vertex) report("popped_vertex", pv, a.popped_vertex);
         if (pk !== a.popped_key) report("popped_key", pk, a.popped_key);
         if (st !== a.status) report("status", st, a.status);
         if (occ !== a.occupancy) report("occupancy", occ, a.occupancy);
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   imq_req_if req_ch ();
   imq_rsp_if rsp_ch ();
   heap_scoreboard sb;
   int quiet_cycles;
   bit steady_mode;

   indexed_min_heap_queue u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_mode || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // item sender: valid stays up across back-to-back items
   task automatic send_item(command_type cmd, logic [VERTEX_W-1:0] vid,
                            logic [KEY_IN_W-1:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.command <= cmd;
      req_ch.vertex_id <= vid;
      req_ch.key_value <= key;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      sb.note(cmd, vid, key);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 0;
      while (sb.answers.size() != 0) @(negedge clock);
   endtask

   function automatic logic [KEY_IN_W-1:0] rand_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VERTEX_W-1:0] absent_vertex();
      logic [VERTEX_W-1:0] v;
      repeat (64) begin
         v = VERTEX_W'($urandom_range(0, VERTEX_SPACE - 1));
         if (!sb.vtx_here[v]) return v;
      end
      return v;
   endfunction

   task automatic random_item();
      int r, pos;
      logic [KEY_IN_W-1:0] k;
      r = $urandom_range(0, 199);
      if (r < 80) send_item(CMD_INSERT, ($urandom_range(0, 9) < 8) ? absent_vertex()
                            : VERTEX_W'($urandom_range(0, VERTEX_SPACE - 1)), rand_key());
      else if (r < 130) begin
         if (sb.count > 0 && $urandom_range(0, 9) < 8) begin
            pos = $urandom_range(0, sb.count - 1);
            k = sb.slot_key[pos];
            if ($urandom_range(0, 7) == 0) k = k + $urandom_range(0, 3);
            else if (k > 0) k = $urandom_range(0, k - 1);
            send_item(CMD_DECREASE, sb.slot_vtx[pos], k);
         end else send_item(CMD_DECREASE, absent_vertex(), rand_key());
      end else if (r < 198) send_item(CMD_DELETE_MIN, VERTEX_W'($urandom), $urandom);
      else send_item(CMD_CLEAR, VERTEX_W'($urandom), $urandom);
   endtask

   // result sink with random stalls
   initial begin
      int stall;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         sb.check(rsp_ch.popped_vertex, rsp_ch.popped_key, rsp_ch.status,
                  rsp_ch.occupancy);
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("indexed_min_heap_queue regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int order[VERTEX_SPACE];
      int tmp, j;
      sb = new();
      sb.wipe();
      steady_mode = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.command = CMD_INSERT;
      req_ch.vertex_id = '0;
      req_ch.key_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed corners
      send_item(CMD_DELETE_MIN, '1, '1);
      send_item(CMD_DECREASE, 10'd5, 32'd1);
      send_item(CMD_INSERT, 10'd1023, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 10'd0, 32'h0000_0000);
      send_item(CMD_INSERT, 10'd1023, 32'd7);
      send_item(CMD_INSERT, 10'd341, 32'h0001_0000);
      send_item(CMD_INSERT, 10'd682, 32'h0001_0000);
      send_item(CMD_DECREASE, 10'd341, 32'h0001_0000);
      send_item(CMD_DECREASE, 10'd682, 32'h0002_0000);
      send_item(CMD_DECREASE, 10'd1023, 32'h0000_0000);
      send_item(CMD_DECREASE, 10'd682, 32'h0000_8000);
      send_item(CMD_DELETE_MIN, '0, '0);
      send_item(CMD_DELETE_MIN, '0, '0);
      send_item(CMD_CLEAR, '1, '1);
      send_item(CMD_DELETE_MIN, '0, '0);
      send_item(CMD_DECREASE, 10'd0, 32'd0);
      send_item(CMD_INSERT, 10'd512, 32'hAAAA_5555);
      send_item(CMD_INSERT, 10'd256, 32'h5555_AAAA);
      send_item(CMD_DELETE_MIN, '0, '0);
      send_item(CMD_DELETE_MIN, '0, '0);
      settle();

      // fill every vertex so the heap holds its full count
      foreach (order[i]) order[i] = i;
      for (int i = VERTEX_SPACE - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (int i = 0; i < VERTEX_SPACE; i++) begin
         steady_mode = (i >= 300 && i < 500);
         send_item(CMD_INSERT, VERTEX_W'(order[i]), rand_key());
      end
      steady_mode = 0;
      send_item(CMD_INSERT, VERTEX_W'($urandom), rand_key());
      for (int i = 0; i < 60; i++) send_item(CMD_DELETE_MIN, '0, '0);

      for (int i = 0; i < 800; i++) begin
         steady_mode = (i >= 400 && i < 520);
         random_item();
      end
      steady_mode = 0;

      settle();
      repeat (60) @(posedge clock);
      $display("checked %0d results: ok %0d, empty %0d, present %0d, absent %0d,",
               sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
               sb.status_seen[STAT_PRESENT], sb.status_seen[STAT_ABSENT]);
      $display("not smaller %0d, including a heap filled to all vertices",
               sb.status_seen[STAT_NOT_SMALLER]);
      if (sb.errors == 0 && sb.answers.size() == 0)
         $display("indexed_min_heap_queue regression: pass");
      else
         $display("indexed_min_heap_queue regression: fail");
      $finish;
   end

endmodule
